[rtl/core/rau_pkg.sv]
// Shared types, codes and helpers for the rational arithmetic unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rau_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned ProdBits = 2 * WordBits;
  localparam int unsigned CntBits  = $clog2(WordBits) + 1;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [ProdBits-1:0] prod_t;

  localparam word_t HalfVal = word_t'(1) << (WordBits - 1);
  localparam word_t MaxPos  = HalfVal - word_t'(1);

  typedef enum logic [2:0] {
    OP_MAKE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_NEG  = 3'd5,
    OP_CMP  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_ZDEN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } cmp_e;

  typedef enum logic [1:0] {
    ALU_GCD = 2'd0,
    ALU_DIV = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // magnitude of a two's complement word; the minimum gives HalfVal
  function automatic word_t abs_word(word_t v);
    return v[WordBits-1] ? (~v + word_t'(1)) : v;
  endfunction

  // product magnitude beyond the signed range for the given sign
  function automatic logic prod_over(prod_t p, logic neg);
    return (p[ProdBits-1:WordBits] != '0) || (p[WordBits-1:0] > (neg ? HalfVal : MaxPos));
  endfunction

endpackage

[rtl/core/rau_alu.sv]
// Iterative shared unit: binary gcd, restoring divide, shift-add multiply.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::alu_req_t req_i,
  input  rau_pkg::word_t    x_i,
  input  rau_pkg::word_t    y_i,
  output logic              done_o,
  output rau_pkg::prod_t    res_o
);
  import rau_pkg::*;

  typedef enum logic [1:0] {
    AS_IDLE = 2'b01,
    AS_RUN  = 2'b10
  } alu_state_e;

  alu_state_e         state_q, state_d;
  alu_op_e            op_q, op_d;
  logic [WordBits:0]  hi_q, hi_d;
  word_t              lo_q, lo_d;
  word_t              y_q, y_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;

  logic [WordBits:0]   msum;
  logic [WordBits:0]   dtrial;
  logic [WordBits+1:0] ddiff;
  word_t               ga, gb;

  assign msum   = hi_q + {1'b0, (lo_q[0] ? y_q : '0)};
  assign dtrial = {hi_q[WordBits-1:0], lo_q[WordBits-1]};
  assign ddiff  = {1'b0, dtrial} - {2'b00, y_q};
  assign ga     = hi_q[WordBits-1:0];
  assign gb     = lo_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    y_d     = y_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          y_d     = y_i;
          cnt_d   = '0;
          state_d = AS_RUN;
          if (req_i.op == ALU_GCD) begin
            hi_d = {1'b0, x_i};
            lo_d = y_i;
          end else begin
            hi_d = '0;
            lo_d = x_i;
          end
        end
      end
      AS_RUN: begin
        case (op_q)
          ALU_MUL: begin
            hi_d  = {1'b0, msum[WordBits:1]};
            lo_d  = {msum[0], lo_q[WordBits-1:1]};
            cnt_d = cnt_q + CntBits'(1);
            if (cnt_q == CntBits'(WordBits - 1)) begin
              done_d  = 1'b1;
              state_d = AS_IDLE;
            end
          end
          ALU_DIV: begin
            hi_d  = ddiff[WordBits+1] ? dtrial : ddiff[WordBits:0];
            lo_d  = {lo_q[WordBits-2:0], ~ddiff[WordBits+1]};
            cnt_d = cnt_q + CntBits'(1);
            if (cnt_q == CntBits'(WordBits - 1)) begin
              done_d  = 1'b1;
              state_d = AS_IDLE;
            end
          end
          default: begin
            if (ga == '0 || gb == '0) begin
              hi_d    = '0;
              lo_d    = (ga == '0 ? gb : ga) << cnt_q;
              done_d  = 1'b1;
              state_d = AS_IDLE;
            end else if (!ga[0] && !gb[0]) begin
              hi_d  = {2'b00, ga[WordBits-1:1]};
              lo_d  = gb >> 1;
              cnt_d = cnt_q + CntBits'(1);
            end else if (!ga[0]) begin
              hi_d = {2'b00, ga[WordBits-1:1]};
            end else if (!gb[0]) begin
              lo_d = gb >> 1;
            end else if (ga >= gb) begin
              hi_d = {1'b0, ga - gb};
            end else begin
              lo_d = gb - ga;
            end
          end
        endcase
      end
      default: state_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    y_q   <= y_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign res_o  = {hi_q[WordBits-1:0], lo_q};

endmodule

[rtl/core/rational_arithmetic_unit.sv]
// Rational arithmetic unit top level: operand normalisation and operation sequencer.
// Depends on rau_pkg and rau_alu.
`timescale 1ns / 1ps

// One transaction in, one result out. Every step runs on a single iterative unit.
// Normalising one fraction costs a gcd and two divides; a zero denominator
// returns early. The input is not ready while a transaction is in progress; a
// finished result waits in the output register while the next one is taken.
module rational_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
  input  logic [2:0]   s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // res_num, res_den, cmp_result, zero pad
  output logic [1:0]   m_axis_tuser   // status
);
  import rau_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE  = 23'd1 << 0,
    S_RGCD  = 23'd1 << 1,
    S_RDIVN = 23'd1 << 2,
    S_RDIVD = 23'd1 << 3,
    S_RCHK  = 23'd1 << 4,
    S_XGCD  = 23'd1 << 5,
    S_XQ1   = 23'd1 << 6,
    S_XQ2   = 23'd1 << 7,
    S_XM1   = 23'd1 << 8,
    S_XM2   = 23'd1 << 9,
    S_XM3   = 23'd1 << 10,
    S_XADD  = 23'd1 << 11,
    S_MG1   = 23'd1 << 12,
    S_MG2   = 23'd1 << 13,
    S_MD1   = 23'd1 << 14,
    S_MD2   = 23'd1 << 15,
    S_MM1   = 23'd1 << 16,
    S_MD3   = 23'd1 << 17,
    S_MD4   = 23'd1 << 18,
    S_MM2   = 23'd1 << 19,
    S_CM1   = 23'd1 << 20,
    S_CM2   = 23'd1 << 21,
    S_DONE  = 23'd1 << 22
  } state_e;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_F = 2'd2
  } phase_e;

  state_e  state_q, state_d;
  phase_e  phase_q, phase_d;
  op_e     op_q, op_d;
  status_e st_q, st_d;
  cmp_e    cmp_q, cmp_d;
  logic    is_cmp_q, is_cmp_d;
  logic    issued_q, issued_d;

  logic  an_neg_q, an_neg_d, bn_neg_q, bn_neg_d, bd_neg_q, bd_neg_d;
  logic  rn_neg_q, rn_neg_d, rd_neg_q, rd_neg_d;
  word_t an_mag_q, an_mag_d, ad_q, ad_d, bn_mag_q, bn_mag_d, bd_mag_q, bd_mag_d;
  word_t rn_mag_q, rn_mag_d, rd_mag_q, rd_mag_d;
  word_t g_q, g_d, h_q, h_d, t1_q, t1_d, t2_q, t2_d;
  prod_t lp_q, lp_d;

  logic          out_valid_q, out_valid_d;
  logic [63:0]   out_num_q, out_num_d;
  logic [62:0]   out_den_q, out_den_d;
  logic [1:0]    out_cmp_q, out_cmp_d;
  status_e       out_st_q, out_st_d;

  alu_req_t alu_req;
  word_t    alu_x, alu_y, alu_lo;
  prod_t    alu_res;
  logic     alu_done, alu_state;

  word_t a_num_w, a_den_w, b_num_w, b_den_w;
  logic  n2_neg, d2_neg;
  word_t n2_mag, d2_mag;
  logic  nneg;
  logic [WordBits:0] xsum;
  logic signed [WordBits-1:0] num_s;
  logic  res_ok;

  assign a_num_w = s_axis_tdata[WordBits-1:0];
  assign a_den_w = s_axis_tdata[64+WordBits-1:64];
  assign b_num_w = s_axis_tdata[128+WordBits-1:128];
  assign b_den_w = s_axis_tdata[192+WordBits-1:192];

  // b or its reciprocal as the second factor
  assign n2_neg = (op_q == OP_MUL) ? bn_neg_q : 1'b0;
  assign n2_mag = (op_q == OP_MUL) ? bn_mag_q : bd_mag_q;
  assign d2_neg = (op_q == OP_MUL) ? 1'b0 : bn_neg_q;
  assign d2_mag = (op_q == OP_MUL) ? bd_mag_q : bn_mag_q;

  assign nneg   = (rn_mag_q != '0) && (rn_neg_q != rd_neg_q);
  assign alu_lo = alu_res[WordBits-1:0];
  assign xsum   = (op_q == OP_SUB) ? ({t1_q[WordBits-1], t1_q} - {t2_q[WordBits-1], t2_q})
                                   : ({t1_q[WordBits-1], t1_q} + {t2_q[WordBits-1], t2_q});
  assign num_s  = rn_neg_q ? signed'(~rn_mag_q + word_t'(1)) : signed'(rn_mag_q);
  assign res_ok = (st_q == ST_OK) && !is_cmp_q;

  // unit operand selection
  always_comb begin
    alu_state = 1'b1;
    alu_req.op = ALU_MUL;
    alu_x = an_mag_q;
    alu_y = h_q;
    case (state_q)
      S_RGCD:  begin alu_req.op = ALU_GCD; alu_x = rn_mag_q; alu_y = rd_mag_q; end
      S_RDIVN: begin alu_req.op = ALU_DIV; alu_x = rn_mag_q; alu_y = g_q; end
      S_RDIVD: begin alu_req.op = ALU_DIV; alu_x = rd_mag_q; alu_y = g_q; end
      S_XGCD:  begin alu_req.op = ALU_GCD; alu_x = ad_q; alu_y = bd_mag_q; end
      S_XQ1:   begin alu_req.op = ALU_DIV; alu_x = bd_mag_q; alu_y = g_q; end
      S_XQ2:   begin alu_req.op = ALU_DIV; alu_x = ad_q; alu_y = g_q; end
      S_XM1:   begin alu_req.op = ALU_MUL; alu_x = an_mag_q; alu_y = h_q; end
      S_XM2:   begin alu_req.op = ALU_MUL; alu_x = bn_mag_q; alu_y = g_q; end
      S_XM3:   begin alu_req.op = ALU_MUL; alu_x = ad_q; alu_y = h_q; end
      S_MG1:   begin alu_req.op = ALU_GCD; alu_x = an_mag_q; alu_y = d2_mag; end
      S_MG2:   begin alu_req.op = ALU_GCD; alu_x = n2_mag; alu_y = ad_q; end
      S_MD1:   begin alu_req.op = ALU_DIV; alu_x = an_mag_q; alu_y = g_q; end
      S_MD2:   begin alu_req.op = ALU_DIV; alu_x = n2_mag; alu_y = h_q; end
      S_MM1:   begin alu_req.op = ALU_MUL; alu_x = t1_q; alu_y = t2_q; end
      S_MD3:   begin alu_req.op = ALU_DIV; alu_x = ad_q; alu_y = h_q; end
      S_MD4:   begin alu_req.op = ALU_DIV; alu_x = d2_mag; alu_y = g_q; end
      S_MM2:   begin alu_req.op = ALU_MUL; alu_x = t1_q; alu_y = t2_q; end
      S_CM1:   begin alu_req.op = ALU_MUL; alu_x = an_mag_q; alu_y = bd_mag_q; end
      S_CM2:   begin alu_req.op = ALU_MUL; alu_x = bn_mag_q; alu_y = ad_q; end
      default: alu_state = 1'b0;
    endcase
    if (state_q == S_RGCD && rd_mag_q == '0) begin
      alu_state = 1'b0;
    end
    alu_req.start = alu_state && !issued_q;
  end

  rau_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .x_i    (alu_x),
    .y_i    (alu_y),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    op_d     = op_q;
    st_d     = st_q;
    cmp_d    = cmp_q;
    is_cmp_d = is_cmp_q;
    issued_d = issued_q;
    an_neg_d = an_neg_q;
    an_mag_d = an_mag_q;
    ad_d     = ad_q;
    bn_neg_d = bn_neg_q;
    bn_mag_d = bn_mag_q;
    bd_neg_d = bd_neg_q;
    bd_mag_d = bd_mag_q;
    rn_neg_d = rn_neg_q;
    rn_mag_d = rn_mag_q;
    rd_neg_d = rd_neg_q;
    rd_mag_d = rd_mag_q;
    g_d      = g_q;
    h_d      = h_q;
    t1_d     = t1_q;
    t2_d     = t2_q;
    lp_d     = lp_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    out_cmp_d   = out_cmp_q;
    out_st_d    = out_st_q;

    if (alu_req.start) begin
      issued_d = 1'b1;
    end
    if (alu_done) begin
      issued_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = op_e'(s_axis_tuser);
          st_d     = ST_OK;
          cmp_d    = CMP_LT;
          is_cmp_d = 1'b0;
          phase_d  = PH_A;
          rn_neg_d = a_num_w[WordBits-1];
          rn_mag_d = abs_word(a_num_w);
          rd_neg_d = a_den_w[WordBits-1];
          rd_mag_d = abs_word(a_den_w);
          bn_neg_d = b_num_w[WordBits-1];
          bn_mag_d = abs_word(b_num_w);
          bd_neg_d = b_den_w[WordBits-1];
          bd_mag_d = abs_word(b_den_w);
          state_d  = S_RGCD;
        end
      end
      S_RGCD: begin
        if (rd_mag_q == '0) begin
          st_d    = ST_ZDEN;
          state_d = S_DONE;
        end else if (alu_done) begin
          g_d     = alu_lo;
          state_d = S_RDIVN;
        end
      end
      S_RDIVN: if (alu_done) begin rn_mag_d = alu_lo; state_d = S_RDIVD; end
      S_RDIVD: if (alu_done) begin rd_mag_d = alu_lo; state_d = S_RCHK; end
      S_RCHK: begin
        rn_neg_d = nneg;
        rd_neg_d = 1'b0;
        if (rd_mag_q > MaxPos || (!nneg && rn_mag_q > MaxPos)) begin
          st_d    = ST_OVF;
          state_d = S_DONE;
        end else begin
          case (phase_q)
            PH_A: begin
              an_neg_d = nneg;
              an_mag_d = rn_mag_q;
              ad_d     = rd_mag_q;
              state_d  = S_DONE;
              case (op_q)
                OP_NEG: begin
                  rn_neg_d = (rn_mag_q != '0) && !nneg;
                  if (nneg && rn_mag_q == HalfVal) begin
                    st_d = ST_OVF;
                  end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
                  rn_neg_d = bn_neg_q;
                  rn_mag_d = bn_mag_q;
                  rd_neg_d = bd_neg_q;
                  rd_mag_d = bd_mag_q;
                  phase_d  = PH_B;
                  state_d  = S_RGCD;
                end
                default: ;
              endcase
            end
            PH_B: begin
              bn_neg_d = nneg;
              bn_mag_d = rn_mag_q;
              bd_neg_d = 1'b0;
              bd_mag_d = rd_mag_q;
              case (op_q)
                OP_ADD, OP_SUB: state_d = S_XGCD;
                OP_MUL:         state_d = S_MG1;
                OP_DIV: begin
                  if (rn_mag_q == '0) begin
                    st_d    = ST_ZDEN;
                    state_d = S_DONE;
                  end else begin
                    state_d = S_MG1;
                  end
                end
                default:        state_d = S_CM1;
              endcase
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_XGCD: if (alu_done) begin g_d = alu_lo; state_d = S_XQ1; end
      S_XQ1:  if (alu_done) begin h_d = alu_lo; state_d = S_XQ2; end
      S_XQ2:  if (alu_done) begin g_d = alu_lo; state_d = S_XM1; end
      S_XM1: begin
        if (alu_done) begin
          t1_d    = an_neg_q ? (~alu_lo + word_t'(1)) : alu_lo;
          state_d = S_XM2;
          if (prod_over(alu_res, an_neg_q)) begin
            st_d    = ST_OVF;
            state_d = S_DONE;
          end
        end
      end
      S_XM2: begin
        if (alu_done) begin
          t2_d    = bn_neg_q ? (~alu_lo + word_t'(1)) : alu_lo;
          state_d = S_XM3;
          if (prod_over(alu_res, bn_neg_q)) begin
            st_d    = ST_OVF;
            state_d = S_DONE;
          end
        end
      end
      S_XM3: begin
        if (alu_done) begin
          rd_mag_d = alu_lo;
          rd_neg_d = 1'b0;
          state_d  = S_XADD;
          if (prod_over(alu_res, 1'b0)) begin
            st_d    = ST_OVF;
            state_d = S_DONE;
          end
        end
      end
      S_XADD: begin
        rn_neg_d = xsum[WordBits-1];
        rn_mag_d = abs_word(xsum[WordBits-1:0]);
        phase_d  = PH_F;
        state_d  = S_RGCD;
        if (xsum[WordBits] != xsum[WordBits-1]) begin
          st_d    = ST_OVF;
          state_d = S_DONE;
        end
      end
      S_MG1: if (alu_done) begin g_d = alu_lo; state_d = S_MG2; end
      S_MG2: if (alu_done) begin h_d = alu_lo; state_d = S_MD1; end
      S_MD1: if (alu_done) begin t1_d = alu_lo; state_d = S_MD2; end
      S_MD2: if (alu_done) begin t2_d = alu_lo; state_d = S_MM1; end
      S_MM1: begin
        if (alu_done) begin
          rn_mag_d = alu_lo;
          rn_neg_d = (alu_lo != '0) && (an_neg_q != n2_neg);
          state_d  = S_MD3;
          if (prod_over(alu_res, 1'b0)) begin
            st_d    = ST_OVF;
            state_d = S_DONE;
          end
        end
      end
      S_MD3: if (alu_done) begin t1_d = alu_lo; state_d = S_MD4; end
      S_MD4: if (alu_done) begin t2_d = alu_lo; state_d = S_MM2; end
      S_MM2: begin
        if (alu_done) begin
          rd_mag_d = alu_lo;
          rd_neg_d = d2_neg;
          phase_d  = PH_F;
          state_d  = S_RGCD;
          if (prod_over(alu_res, 1'b0)) begin
            st_d    = ST_OVF;
            state_d = S_DONE;
          end
        end
      end
      S_CM1: if (alu_done) begin lp_d = alu_res; state_d = S_CM2; end
      S_CM2: begin
        if (alu_done) begin
          is_cmp_d = 1'b1;
          state_d  = S_DONE;
          if (an_neg_q != bn_neg_q) begin
            cmp_d = an_neg_q ? CMP_LT : CMP_GT;
          end else if (lp_q == alu_res) begin
            cmp_d = CMP_EQ;
          end else if ((lp_q > alu_res) != an_neg_q) begin
            cmp_d = CMP_GT;
          end else begin
            cmp_d = CMP_LT;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_num_d   = res_ok ? 64'(num_s) : '0;
          out_den_d   = res_ok ? 63'(rd_mag_q) : '0;
          out_cmp_d   = (st_q == ST_OK && is_cmp_q) ? cmp_q : CMP_LT;
          out_st_d    = st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q   <= phase_d;
    op_q      <= op_d;
    st_q      <= st_d;
    cmp_q     <= cmp_d;
    is_cmp_q  <= is_cmp_d;
    an_neg_q  <= an_neg_d;
    an_mag_q  <= an_mag_d;
    ad_q      <= ad_d;
    bn_neg_q  <= bn_neg_d;
    bn_mag_q  <= bn_mag_d;
    bd_neg_q  <= bd_neg_d;
    bd_mag_q  <= bd_mag_d;
    rn_neg_q  <= rn_neg_d;
    rn_mag_q  <= rn_mag_d;
    rd_neg_q  <= rd_neg_d;
    rd_mag_q  <= rd_mag_d;
    g_q       <= g_d;
    h_q       <= h_d;
    t1_q      <= t1_d;
    t2_q      <= t2_d;
    lp_q      <= lp_d;
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
    out_cmp_q <= out_cmp_d;
    out_st_q  <= out_st_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_cmp_q, out_den_q, out_num_q};
  assign m_axis_tuser  = out_st_q;

endmodule

[rtl/core/rau_checker.sv]
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit.
`timescale 1ns / 1ps

module rau_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  import rau_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("error result carries data");

  a_cmp_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[128:127] != CMP_LT |-> m_axis_tdata[126:0] == '0)
    else $error("compare result carries a fraction");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/tb_rational_arithmetic_unit.sv]
// Testbench for rational_arithmetic_unit: directed and random fraction transactions,
// checked against an in-bench predictor of reduced results. Uses rau_pkg and the DUT.
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam logic [2:0] OpSpare = 3'd7;
  localparam int unsigned CycleLimit = 8000000;
  localparam int unsigned QuietFrom = 60000;
  localparam int unsigned QuietTo = 200000;

  typedef struct {
    bit         neg;
    logic [63:0] mag;
  } sval_t;

  typedef struct {
    bit          drain;
    logic [2:0]  op;
    logic [63:0] an, ad, bn, bd;
  } frac_item_t;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic [1:0]  cmp;
    logic [1:0]  st;
  } frac_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [255:0] s_data = '0;
  logic [2:0]   s_user = '0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [135:0] m_data;
  logic [1:0]   m_user;

  logic         s_taken = 1'b0;
  int unsigned  cyc = 0;
  int unsigned  errs = 0;
  frac_item_t   pending_q[$];
  frac_res_t    expected_q[$];

  rational_arithmetic_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  always #5 clk_i = ~clk_i;

  // ---------------- predictor ----------------
  function automatic sval_t to_sval(logic [63:0] v);
    sval_t r;
    r.neg = v[63];
    r.mag = v[63] ? (~v + 64'd1) : v;
    return r;
  endfunction

  function automatic sval_t mag_only(logic [63:0] m);
    sval_t r;
    r.neg = 1'b0;
    r.mag = m;
    return r;
  endfunction

  function automatic bit in_range(sval_t x);
    return x.neg ? (x.mag <= HalfVal) : (x.mag <= MaxPos);
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic sval_t flip(sval_t x);
    if (x.mag != 0) x.neg = !x.neg;
    return x;
  endfunction

  function automatic status_e frac_reduce(sval_t n, sval_t d, output sval_t on,
                                          output logic [63:0] od);
    logic [63:0] g;
    if (d.mag == 0) return ST_ZDEN;
    g = gcd64(n.mag, d.mag);
    n.mag = n.mag / g;
    d.mag = d.mag / g;
    n.neg = (n.mag != 0) && (n.neg != d.neg);
    if (d.mag > MaxPos || !in_range(n)) return ST_OVF;
    on = n;
    od = d.mag;
    return ST_OK;
  endfunction

  function automatic status_e checked_mul(sval_t a, sval_t b, output sval_t r);
    logic [127:0] p;
    bit neg;
    neg = (a.neg != b.neg) && a.mag != 0 && b.mag != 0;
    p = {64'd0, a.mag} * {64'd0, b.mag};
    if (p > {64'd0, (neg ? HalfVal : MaxPos)}) return ST_OVF;
    r.neg = neg;
    r.mag = p[63:0];
    return ST_OK;
  endfunction

  function automatic status_e checked_add(sval_t a, sval_t b, output sval_t r);
    sval_t s;
    logic [63:0] lim;
    if (a.mag == 0) s = b;
    else if (b.mag == 0) s = a;
    else if (a.neg == b.neg) begin
      lim = a.neg ? HalfVal : MaxPos;
      if (a.mag > lim || b.mag > lim - a.mag) return ST_OVF;
      s.neg = a.neg;
      s.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      s.neg = a.neg;
      s.mag = a.mag - b.mag;
    end else begin
      s.neg = b.neg;
      s.mag = b.mag - a.mag;
    end
    if (s.mag == 0) s.neg = 1'b0;
    if (!in_range(s)) return ST_OVF;
    r = s;
    return ST_OK;
  endfunction

  function automatic frac_res_t predict_fraction(frac_item_t it);
    frac_res_t   res;
    sval_t       an, bn, rn, t1, t2, c, x, n2, d2;
    logic [63:0] ad, bd, rd, g, h;
    logic [127:0] lp, rp;
    status_e     st;
    logic [1:0]  cmpv;
    bit          is_cmp;
    rn = mag_only(0);
    rd = 64'd1;
    cmpv = CMP_LT;
    is_cmp = 1'b0;
    st = frac_reduce(to_sval(it.an), to_sval(it.ad), an, ad);
    if (st == ST_OK) begin
      if (it.op == OP_MAKE || it.op == OpSpare) begin
        rn = an;
        rd = ad;
      end else if (it.op == OP_NEG) begin
        rn = flip(an);
        rd = ad;
        if (!in_range(rn)) st = ST_OVF;
      end else begin
        st = frac_reduce(to_sval(it.bn), to_sval(it.bd), bn, bd);
        if (st == ST_OK && it.op == OP_DIV && bn.mag == 0) st = ST_ZDEN;
        if (st == ST_OK && (it.op == OP_ADD || it.op == OP_SUB)) begin
          g = gcd64(ad, bd);
          st = checked_mul(an, mag_only(bd / g), t1);
          if (st == ST_OK) st = checked_mul(bn, mag_only(ad / g), t2);
          if (st == ST_OK) st = checked_mul(mag_only(ad), mag_only(bd / g), c);
          if (st == ST_OK) st = checked_add(t1, (it.op == OP_SUB) ? flip(t2) : t2, x);
          if (st == ST_OK) st = frac_reduce(x, c, rn, rd);
        end else if (st == ST_OK && (it.op == OP_MUL || it.op == OP_DIV)) begin
          n2 = (it.op == OP_MUL) ? bn : mag_only(bd);
          d2 = (it.op == OP_MUL) ? mag_only(bd) : bn;
          g = gcd64(an.mag, d2.mag);
          h = gcd64(n2.mag, ad);
          st = checked_mul(mag_only(an.mag / g), mag_only(n2.mag / h), t1);
          t1.neg = (t1.mag != 0) && (an.neg != n2.neg);
          if (st == ST_OK) st = checked_mul(mag_only(ad / h), mag_only(d2.mag / g), t2);
          t2.neg = (t2.mag != 0) && d2.neg;
          if (st == ST_OK && !(in_range(t1) && in_range(t2))) st = ST_OVF;
          if (st == ST_OK) st = frac_reduce(t1, t2, rn, rd);
        end else if (st == ST_OK) begin
          is_cmp = 1'b1;
          lp = {64'd0, an.mag} * {64'd0, bd};
          rp = {64'd0, bn.mag} * {64'd0, ad};
          if (an.neg != bn.neg) cmpv = an.neg ? CMP_LT : CMP_GT;
          else if (lp == rp) cmpv = CMP_EQ;
          else cmpv = ((lp < rp) != an.neg) ? CMP_LT : CMP_GT;
        end
      end
    end
    if (st != ST_OK || is_cmp) begin
      res.num = '0;
      res.den = '0;
    end else begin
      res.num = rn.neg ? (~rn.mag + 64'd1) : rn.mag;
      res.den = rd[62:0];
    end
    res.cmp = (st == ST_OK && is_cmp) ? cmpv : CMP_LT;
    res.st = st;
    return res;
  endfunction

  // ---------------- stimulus ----------------
  function automatic logic [63:0] rand_word(bit is_den);
    logic [63:0] v;
    case ($urandom_range(0, 15))
      0, 1:    v = {$urandom, $urandom};
      2:       v = HalfVal;
      3:       v = MaxPos;
      4:       v = 64'd0;
      5:       v = $urandom_range(0, 1) ? 64'd1 : '1;
      12, 13:  v = {{32{1'b0}}, $urandom};
      14:      v = HalfVal + 64'($urandom_range(0, 50));
      15:      v = 64'($urandom_range(1, 60)) << $urandom_range(0, 57);
      default: v = 64'($urandom_range(0, 200));
    endcase
    if ($urandom_range(0, 1)) v = ~v + 64'd1;
    if (is_den && v == 0 && $urandom_range(0, 3) != 0) v = 64'd1;
    return v;
  endfunction

  task automatic add_item(logic [2:0] op, logic [63:0] an, logic [63:0] ad,
                          logic [63:0] bn, logic [63:0] bd);
    frac_item_t it;
    it.drain = 1'b0;
    it.op = op;
    it.an = an;
    it.ad = ad;
    it.bn = bn;
    it.bd = bd;
    pending_q.push_back(it);
  endtask

  task automatic add_drain();
    frac_item_t it;
    it = '{default: '0};
    it.drain = 1'b1;
    pending_q.push_back(it);
  endtask

  function automatic bit idle_now();
    if (cyc >= QuietFrom && cyc < QuietTo) return 1'b0;
    return $urandom_range(0, 99) < 23;
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    frac_item_t it;
    logic nv;
    if (rst_ni) begin
      nv = s_valid && !s_taken;
      if (!nv) begin
        if (pending_q.size() != 0 && pending_q[0].drain && expected_q.size() == 0)
          void'(pending_q.pop_front());
        if (pending_q.size() != 0 && !pending_q[0].drain && !idle_now()) begin
          it = pending_q.pop_front();
          nv = 1'b1;
          s_data <= {it.bd, it.bn, it.ad, it.an};
          s_user <= it.op;
        end
      end
      s_valid <= nv;
      m_ready <= !idle_now();
    end
  end

  // monitor: sample on the rising edge
  always @(posedge clk_i) begin
    frac_item_t it;
    frac_res_t  got, want;
    cyc <= cyc + 1;
    s_taken <= s_valid && s_ready;
    if (rst_ni && s_valid && s_ready) begin
      it.drain = 1'b0;
      it.op = s_user;
      {it.bd, it.bn, it.ad, it.an} = s_data;
      expected_q.push_back(predict_fraction(it));
    end
    if (rst_ni && m_valid && m_ready) begin
      got.num = m_data[63:0];
      got.den = m_data[126:64];
      got.cmp = m_data[128:127];
      got.st = m_user;
      if (expected_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result transaction num=%h", got.num);
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: exp num=%h den=%h cmp=%0d st=%0d / got num=%h den=%h cmp=%0d st=%0d",
                     want.num, want.den, want.cmp, want.st,
                     got.num, got.den, got.cmp, got.st);
        end
      end
    end
    if (cyc > CycleLimit) begin
      $display("FAIL rational_arithmetic_unit");
      $finish;
    end
  end

  initial begin
    logic [63:0] mn;
    mn = HalfVal;
    // directed
    add_item(OP_MAKE, 64'd6, -64'sd4, 64'd0, 64'd0);
    add_item(OP_MAKE, 64'd5, 64'd0, 64'd1, 64'd1);
    add_item(OP_MAKE, mn, '1, 64'd1, 64'd1);
    add_item(OP_MAKE, 64'd1, mn, 64'd1, 64'd1);
    add_item(OP_MAKE, mn, mn, 64'd3, 64'd0);
    add_item(OpSpare, MaxPos, MaxPos, 64'd0, 64'd0);
    add_item(OP_NEG, mn, 64'd1, 64'd0, 64'd0);
    add_item(OP_NEG, -64'sd3, 64'd9, 64'd0, 64'd0);
    add_item(OP_NEG, 64'd0, -64'sd7, 64'd0, 64'd0);
    add_item(OP_ADD, 64'd1, 64'd2, 64'd1, 64'd3);
    add_item(OP_ADD, MaxPos, 64'd1, 64'd1, 64'd1);
    add_item(OP_ADD, 64'd1, 64'd0, 64'd1, 64'd1);
    add_item(OP_ADD, 64'd1, 64'd1, 64'd1, 64'd0);
    add_item(OP_SUB, 64'd1, 64'd2, 64'd1, 64'd2);
    add_item(OP_SUB, mn, 64'd1, 64'd1, 64'd1);
    add_item(OP_MUL, 64'd4, 64'd9, 64'd3, 64'd8);
    add_item(OP_MUL, MaxPos, 64'd1, 64'd2, 64'd1);
    add_item(OP_MUL, mn, 64'd1, '1, 64'd1);
    add_item(OP_DIV, 64'd2, 64'd3, 64'd0, 64'd5);
    add_item(OP_DIV, -64'sd2, 64'd3, -64'sd4, 64'd9);
    add_item(OP_DIV, 64'd0, 64'd0, 64'd0, 64'd5);
    add_item(OP_CMP, 64'd1, 64'd3, 64'd1, 64'd2);
    add_item(OP_CMP, -64'sd2, 64'd4, 64'd1, -64'sd2);
    add_item(OP_CMP, MaxPos, 64'd1, MaxPos - 64'd1, 64'd1);
    add_item(OP_CMP, mn + 64'd1, 64'd3, -64'sd1, MaxPos);
    add_drain();
    // random
    for (int i = 0; i < 1150; i++) begin
      add_item(($urandom_range(0, 40) == 0) ? OpSpare : 3'($urandom_range(0, 6)),
               rand_word(1'b0), rand_word(1'b1), rand_word(1'b0), rand_word(1'b1));
      if (i == 500) add_drain();
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !s_valid && expected_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (errs == 0 && expected_q.size() == 0) begin
      $display("PASS rational_arithmetic_unit");
    end else begin
      $display("FAIL rational_arithmetic_unit");
    end
    $finish;
  end

endmodule
